### sv/gpt_hv_pkg.sv
`default_nettype none
package gpt_hv_pkg;

    localparam int unsigned POS_W  = 27;
    localparam int unsigned BYTES_W = 28;
    localparam int unsigned SECT_W = 18;
    localparam int unsigned SEC_W  = 13;
    localparam int unsigned OUT_W  = 336;

    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [31:0] MAX_ENTRY_COUNT  = 32'd16384;
    localparam logic [31:0] MAX_ENTRY_BYTES  = 32'd4096;
    localparam logic [31:0] MIN_ENTRY_BYTES  = 32'd128;
    localparam logic [31:0] MIN_HEADER_BYTES = 32'd92;
    localparam logic [BYTES_W-1:0] MAX_ARRAY_BYTES = BYTES_W'(64 * 1024 * 1024);
    localparam logic [SEC_W-1:0] SEC_MIN = 13'd512;
    localparam logic [SEC_W-1:0] SEC_MAX = 13'd4096;

    localparam logic [POS_W-1:0] P_SIG_END  = 27'd7;
    localparam logic [POS_W-1:0] P_REV      = 27'd11;
    localparam logic [POS_W-1:0] P_HSIZE    = 27'd15;
    localparam logic [POS_W-1:0] P_ZERO_LO  = 27'd16;
    localparam logic [POS_W-1:0] P_HCRC     = 27'd19;
    localparam logic [POS_W-1:0] P_CUR      = 27'd31;
    localparam logic [POS_W-1:0] P_ALT      = 27'd39;
    localparam logic [POS_W-1:0] P_FIRST    = 27'd47;
    localparam logic [POS_W-1:0] P_LAST     = 27'd55;
    localparam logic [POS_W-1:0] P_ALBA     = 27'd79;
    localparam logic [POS_W-1:0] P_CNT      = 27'd83;
    localparam logic [POS_W-1:0] P_ESZ      = 27'd87;
    localparam logic [POS_W-1:0] P_ACRC     = 27'd91;

    typedef enum logic [3:0] {
        STAT_OK          = 4'd0,
        STAT_LBA_OUT     = 4'd1,
        STAT_BAD_SIG     = 4'd2,
        STAT_HDR_SIZE    = 4'd3,
        STAT_CUR_LBA     = 4'd4,
        STAT_GEOMETRY    = 4'd5,
        STAT_TOO_LARGE   = 4'd6,
        STAT_ARR_OUT     = 4'd7,
        STAT_ALT_LBA     = 4'd8,
        STAT_USABLE      = 4'd9,
        STAT_ARR_OVERLAP = 4'd10,
        STAT_HDR_OVERLAP = 4'd11
    } status_t;

    typedef enum logic [1:0] {
        CFG_HEADER_LBA    = 2'd0,
        CFG_TOTAL_SECTORS = 2'd1,
        CFG_SECTOR_BYTES  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic    restart;
        logic    hdr_byte;
        logic    arr_byte;
        logic    hend;
        logic    mul_load;
        logic    div_start;
        logic    place;
        logic    fit;
        logic    emit;
        status_t code;
        logic    eok_en;
    } hv_cmd_t;

    typedef struct packed {
        logic out_free;
        logic lba_out;
        logic sig_fail;
        logic size_fail;
        logic hdr_last;
        logic arr_last;
        logic lba_mismatch;
        logic geom_bad;
        logic too_large;
        logic div_done;
        logic outside;
        logic alt_bad;
        logic range_bad;
        logic overlap;
        logic hdr_in;
    } hv_status_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0: r = 8'h45;
            3'd1: r = 8'h46;
            3'd2: r = 8'h49;
            3'd3: r = 8'h20;
            3'd4: r = 8'h50;
            3'd5: r = 8'h41;
            3'd6: r = 8'h52;
            default: r = 8'h54;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/gpt_hv_div.sv
`default_nettype none
module gpt_hv_div
    import gpt_hv_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [POS_W-1:0]   dividend,
    input  wire logic [SEC_W-1:0]   divisor,
    output logic                    done,
    output logic [SECT_W-1:0]       quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [SEC_W-1:0] rem_reg;
    logic [POS_W-1:0] quo_reg;
    logic [SEC_W:0]   shifted;
    logic             ge;
    logic [SEC_W-1:0] rem_next;
    logic [POS_W-1:0] quo_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[POS_W-1]};
        ge       = shifted >= {1'b0, divisor};
        rem_next = ge ? SEC_W'(shifted - {1'b0, divisor}) : shifted[SEC_W-1:0];
        quo_next = {quo_reg[POS_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(POS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SECT_W-1:0];

endmodule
`default_nettype wire

### sv/gpt_hv_dp.sv
`default_nettype none
module gpt_hv_dp
    import gpt_hv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [7:0]       data_byte,
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_wdata,
    input  wire hv_cmd_t          cmd,
    output hv_status_t            sts,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [OUT_W-1:0]      m_tdata
);

    logic [63:0]      hlba_reg, total_reg;
    logic [SEC_W-1:0] sector_reg, sec_eff;

    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [31:0]      crc_reg, crc_next, crc_cur;
    logic [63:0]      shift_reg, shift_next, shift_cur;
    logic             sig_reg, sig_next, sig_cur;
    logic             hm_reg, hm_next;
    logic [31:0]      shcrc_reg, shcrc_next, sacrc_reg, sacrc_next;
    logic [31:0]      rev_reg, rev_next, hsize_reg, hsize_next, hsize_cur;
    logic [63:0]      cur_reg, cur_next, alt_reg, alt_next;
    logic [63:0]      first_reg, first_next, last_reg, last_next, alba_reg, alba_next;
    logic [31:0]      cnt_reg, cnt_next, esz_reg, esz_next;
    logic [BYTES_W-1:0] bytes_reg;
    logic [63:0]      diff_reg, alast_reg;
    logic             ge_reg;
    logic [7:0]       crc_in;
    logic             crc_en;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             div_done;
    logic [SECT_W-1:0] sectors;
    logic             eok;

    always_comb begin
        if (sector_reg < SEC_MIN) begin
            sec_eff = SEC_MIN;
        end else if (sector_reg > SEC_MAX) begin
            sec_eff = SEC_MAX;
        end else begin
            sec_eff = sector_reg;
        end
    end

    always_comb begin
        pos_cur   = cmd.restart ? '0 : pos_reg;
        crc_cur   = cmd.restart ? CRC_ONES : crc_reg;
        shift_cur = cmd.restart ? '0 : shift_reg;
        sig_cur   = cmd.restart ? 1'b1 : sig_reg;
        hsize_cur = cmd.restart ? '0 : hsize_reg;

        shift_next = shift_cur;
        sig_next   = sig_cur;
        pos_next   = pos_cur;
        crc_next   = crc_cur;
        hm_next    = cmd.restart ? 1'b0 : hm_reg;
        shcrc_next = cmd.restart ? '0 : shcrc_reg;
        sacrc_next = cmd.restart ? '0 : sacrc_reg;
        rev_next   = cmd.restart ? '0 : rev_reg;
        hsize_next = hsize_cur;
        cur_next   = cmd.restart ? '0 : cur_reg;
        alt_next   = cmd.restart ? '0 : alt_reg;
        first_next = cmd.restart ? '0 : first_reg;
        last_next  = cmd.restart ? '0 : last_reg;
        alba_next  = cmd.restart ? '0 : alba_reg;
        cnt_next   = cmd.restart ? '0 : cnt_reg;
        esz_next   = cmd.restart ? '0 : esz_reg;

        crc_en = (pos_cur < P_ZERO_LO) || ({5'd0, pos_cur} < hsize_cur);
        crc_in = ((pos_cur >= P_ZERO_LO) && (pos_cur <= P_HCRC)) ? 8'd0 : data_byte;

        if (cmd.hdr_byte) begin
            shift_next = {data_byte, shift_cur[63:8]};
            if ((pos_cur[POS_W-1:3] == '0) && (data_byte != sig_byte(pos_cur[2:0]))) begin
                sig_next = 1'b0;
            end
            if (crc_en) begin
                crc_next = crc_byte(crc_cur, crc_in);
            end
            pos_next = pos_cur + POS_W'(1);
            unique case (pos_cur)
                P_REV:   rev_next   = shift_next[63:32];
                P_HSIZE: hsize_next = shift_next[63:32];
                P_HCRC:  shcrc_next = shift_next[63:32];
                P_CUR:   cur_next   = shift_next;
                P_ALT:   alt_next   = shift_next;
                P_FIRST: first_next = shift_next;
                P_LAST:  last_next  = shift_next;
                P_ALBA:  alba_next  = shift_next;
                P_CNT:   cnt_next   = shift_next[63:32];
                P_ESZ:   esz_next   = shift_next[63:32];
                P_ACRC:  sacrc_next = shift_next[63:32];
                default: ;
            endcase
        end
        if (cmd.arr_byte) begin
            crc_next = crc_byte(crc_reg, data_byte);
            pos_next = pos_reg + POS_W'(1);
        end
        if (cmd.hend) begin
            hm_next = (~crc_reg) == shcrc_reg;
        end
        if (cmd.fit) begin
            pos_next = '0;
            crc_next = CRC_ONES;
        end
    end

    assign eok = (~crc_reg) == sacrc_reg;

    always_comb begin
        sts.out_free     = !out_valid_reg || m_tready;
        sts.lba_out      = hlba_reg >= total_reg;
        sts.sig_fail     = (pos_cur == P_SIG_END) && !sig_next;
        sts.size_fail    = (pos_cur == P_HSIZE) &&
                           ((hsize_next < MIN_HEADER_BYTES) ||
                            (hsize_next > {19'd0, sec_eff}));
        sts.hdr_last     = pos_cur == (POS_W'(sec_eff) - POS_W'(1));
        sts.arr_last     = {1'b0, pos_reg + POS_W'(1)} == bytes_reg;
        sts.lba_mismatch = cur_reg != hlba_reg;
        sts.geom_bad     = (esz_reg < MIN_ENTRY_BYTES) || (esz_reg > MAX_ENTRY_BYTES) ||
                           (cnt_reg == '0) || (cnt_reg > MAX_ENTRY_COUNT);
        sts.too_large    = bytes_reg > MAX_ARRAY_BYTES;
        sts.div_done     = div_done;
        sts.outside      = ge_reg || ({46'd0, sectors} > diff_reg);
        sts.alt_bad      = (alt_reg >= total_reg) || (alt_reg == cur_reg);
        sts.range_bad    = (first_reg > last_reg) || (last_reg >= total_reg);
        sts.overlap      = !((alast_reg < first_reg) || (alba_reg > last_reg));
        sts.hdr_in       = (cur_reg >= first_reg) && (cur_reg <= last_reg);
    end

    gpt_hv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (POS_W'(bytes_reg + BYTES_W'(sec_eff) - BYTES_W'(1))),
        .divisor  (sec_eff),
        .done     (div_done),
        .quotient (sectors)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hlba_reg      <= 64'd1;
            total_reg     <= '0;
            sector_reg    <= SEC_MIN;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_HEADER_LBA:    hlba_reg   <= cfg_wdata;
                    CFG_TOTAL_SECTORS: total_reg  <= cfg_wdata;
                    CFG_SECTOR_BYTES:  sector_reg <= cfg_wdata[SEC_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        crc_reg   <= crc_next;
        shift_reg <= shift_next;
        sig_reg   <= sig_next;
        hm_reg    <= hm_next;
        shcrc_reg <= shcrc_next;
        sacrc_reg <= sacrc_next;
        rev_reg   <= rev_next;
        hsize_reg <= hsize_next;
        cur_reg   <= cur_next;
        alt_reg   <= alt_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        alba_reg  <= alba_next;
        cnt_reg   <= cnt_next;
        esz_reg   <= esz_next;
        if (cmd.mul_load) begin
            bytes_reg <= BYTES_W'(cnt_reg[14:0]) * BYTES_W'(esz_reg[12:0]);
        end
        if (cmd.place) begin
            ge_reg   <= alba_reg >= total_reg;
            diff_reg <= total_reg - alba_reg;
        end
        if (cmd.fit) begin
            alast_reg <= alba_reg + {46'd0, sectors} - 64'd1;
        end
        if (cmd.emit) begin
            out_data_reg <= {1'b0, esz_next[12:0], cnt_next[14:0], alba_next, last_next,
                             first_next, alt_next, hsize_next[12:0], rev_next,
                             cmd.eok_en & eok, hm_next, cmd.code};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

### sv/gpt_hv_ctrl.sv
`default_nettype none
module gpt_hv_ctrl
    import gpt_hv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tuser,
    output logic            s_tready,
    input  wire hv_status_t sts,
    output hv_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_HDR, S_ARR, S_HEND, S_SIZE, S_DIV, S_PLACE, S_FIT,
        S_C8, S_C9, S_C10, S_C11
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE) || (state_reg == S_HDR) || (state_reg == S_ARR);
        s_tready   = in_ready && sts.out_free;

        unique case (state_reg)
            S_IDLE, S_HDR, S_ARR: begin
                if (s_tvalid && sts.out_free) begin
                    if (s_tuser) begin
                        cmd.restart = 1'b1;
                    end
                    if (s_tuser && sts.lba_out) begin
                        cmd.emit   = 1'b1;
                        cmd.code   = STAT_LBA_OUT;
                        state_next = S_IDLE;
                    end else if (s_tuser || state_reg == S_HDR) begin
                        cmd.hdr_byte = 1'b1;
                        priority if (sts.sig_fail) begin
                            cmd.emit   = 1'b1;
                            cmd.code   = STAT_BAD_SIG;
                            state_next = S_IDLE;
                        end else if (sts.size_fail) begin
                            cmd.emit   = 1'b1;
                            cmd.code   = STAT_HDR_SIZE;
                            state_next = S_IDLE;
                        end else if (sts.hdr_last) begin
                            state_next = S_HEND;
                        end else begin
                            state_next = S_HDR;
                        end
                    end else if (state_reg == S_ARR) begin
                        cmd.arr_byte = 1'b1;
                        if (sts.arr_last) begin
                            state_next = S_C8;
                        end
                    end
                end
            end
            S_HEND: begin
                if (sts.out_free) begin
                    cmd.hend = 1'b1;
                    priority if (sts.lba_mismatch) begin
                        cmd.emit   = 1'b1;
                        cmd.code   = STAT_CUR_LBA;
                        state_next = S_IDLE;
                    end else if (sts.geom_bad) begin
                        cmd.emit   = 1'b1;
                        cmd.code   = STAT_GEOMETRY;
                        state_next = S_IDLE;
                    end else begin
                        cmd.mul_load = 1'b1;
                        state_next   = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                if (sts.out_free) begin
                    if (sts.too_large) begin
                        cmd.emit   = 1'b1;
                        cmd.code   = STAT_TOO_LARGE;
                        state_next = S_IDLE;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = S_FIT;
            end
            S_FIT: begin
                if (sts.out_free) begin
                    if (sts.outside) begin
                        cmd.emit   = 1'b1;
                        cmd.code   = STAT_ARR_OUT;
                        state_next = S_IDLE;
                    end else begin
                        cmd.fit    = 1'b1;
                        state_next = S_ARR;
                    end
                end
            end
            S_C8: begin
                if (sts.out_free) begin
                    if (sts.alt_bad) begin
                        cmd.emit   = 1'b1;
                        cmd.eok_en = 1'b1;
                        cmd.code   = STAT_ALT_LBA;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_C9;
                    end
                end
            end
            S_C9: begin
                if (sts.range_bad) begin
                    cmd.emit   = 1'b1;
                    cmd.eok_en = 1'b1;
                    cmd.code   = STAT_USABLE;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_C10;
                end
            end
            S_C10: begin
                if (sts.overlap) begin
                    cmd.emit   = 1'b1;
                    cmd.eok_en = 1'b1;
                    cmd.code   = STAT_ARR_OVERLAP;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_C11;
                end
            end
            S_C11: begin
                cmd.emit   = 1'b1;
                cmd.eok_en = 1'b1;
                cmd.code   = sts.hdr_in ? STAT_HDR_OVERLAP : STAT_OK;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### sv/gpt_header_validator_unit.sv
// Channel  | Ports           | Payload (lowest bit first)
// s_ item  | s_tvalid/tready | tdata: data_byte[7:0]; tuser: first_of_table
// m_ item  | m_tvalid/tready | tdata: status, header_crc_good, entries_crc_good, revision_word,
//          |                 |   header_length, alternate_lba, usable_first, usable_last,
//          |                 |   array_lba, number_of_entries, bytes_per_entry, zero pad
// cfg      | cfg_wr_en       | cfg_index, cfg_wdata[63:0]
// Header and array bytes feed a bytewise CRC-32 unit. Header end runs LBA and geometry
// checks, the entry product and size check, and a 27-step shift-subtract divider for the
// array sector count, then the placement check. Array end runs the alternate LBA, usable
// range and overlap checks. A result stays in the output register until taken; input stalls
// while it cannot be replaced and during end checks. aresetn is synchronous, active low.
`default_nettype none
module gpt_header_validator_unit
    import gpt_hv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // data_byte
    input  wire logic             s_tuser,   // first_of_table
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // status .. bytes_per_entry, pad
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_wdata
);

    hv_cmd_t    cmd;
    hv_status_t sts;

    gpt_hv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gpt_hv_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

### sv/gpt_hv_checker.sv
`default_nettype none
module gpt_hv_checker
    import gpt_hv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= 4'd11)
        else $error("status out of range");

    a_hcrc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:0] == 4'd1 || m_tdata[3:0] == 4'd2 || m_tdata[3:0] == 4'd3)
        |-> !m_tdata[4])
        else $error("header crc flag set on early failure");

    a_ecrc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] >= 4'd1 && m_tdata[3:0] <= 4'd7 |-> !m_tdata[5])
        else $error("entries crc flag set before array end");

endmodule

bind gpt_header_validator_unit gpt_hv_checker u_hv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### test/tb_gpt_header_validator_unit.sv
`default_nettype none
module tb_gpt_header_validator_unit;
    import gpt_hv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {PH_IDLE, PH_HDR, PH_ARR} phase_t;

    typedef struct {
        status_t     status;
        logic        hcrc_ok;
        logic        ecrc_ok;
        logic [31:0] rev;
        logic [12:0] hlen;
        logic [63:0] alt;
        logic [63:0] ufirst;
        logic [63:0] ulast;
        logic [63:0] alba;
        logic [14:0] nent;
        logic [12:0] esz;
    } verdict_t;

    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE = 60;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_wr_en = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [63:0]      cfg_wdata = '0;

    gpt_header_validator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    logic [8:0] pending_bytes[$];
    verdict_t   expected_verdicts[$];
    int n_items = 0, n_results = 0, n_checked = 0, n_tables = 0, errors = 0;
    int stat_seen[16];
    logic quiet = 1'b0, hold_req = 1'b0, hold_done = 1'b0;
    int send_gap = 0, rx_gap = 0, hold_cnt = 0, wdog = 0;

    // predictor state
    logic [63:0] cf_hdr_lba = 64'd1, cf_total = 64'd0;
    logic [12:0] cf_sec = 13'd512;
    logic [26:0] pos;
    phase_t      ph = PH_IDLE;
    logic [31:0] crc, st_hcrc, st_acrc;
    logic        hmatch, sig_ok;
    logic [63:0] shreg;
    logic [63:0] cap[8];
    logic [7:0]  gpt_magic[8] = '{8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54};

    function automatic logic [63:0] eff_ss();
        if (cf_sec < 13'd512) return 64'd512;
        if (cf_sec > 13'd4096) return 64'd4096;
        return {51'd0, cf_sec};
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return r;
    endfunction

    task automatic close_table(input status_t code, input logic eok, output verdict_t v);
        v.status  = code;
        v.hcrc_ok = hmatch;
        v.ecrc_ok = eok;
        v.rev     = cap[0][31:0];
        v.hlen    = cap[1][12:0];
        v.alt     = cap[3];
        v.ufirst  = cap[4];
        v.ulast   = cap[5];
        v.alba    = cap[6];
        v.nent    = cap[7][14:0];
        v.esz     = cap[7][44:32];
        ph = PH_IDLE;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic first,
                                output logic got, output verdict_t v);
        logic [63:0] p, ss, cnt, esz, nbytes, sects, afirst, alast;
        logic eok;
        got = 1'b0;
        ss = eff_ss();
        if (first) begin
            pos = '0; ph = PH_HDR; crc = '1; st_hcrc = '0; st_acrc = '0;
            hmatch = 1'b0; shreg = '0; sig_ok = 1'b1;
            for (int k = 0; k < 8; k++) cap[k] = '0;
            if (cf_hdr_lba >= cf_total) begin
                close_table(STAT_LBA_OUT, 1'b0, v); got = 1'b1; return;
            end
        end
        cnt = {32'd0, cap[7][31:0]};
        esz = {32'd0, cap[7][63:32]};
        if (ph == PH_HDR) begin
            p = {37'd0, pos};
            if (p < 8 && b != gpt_magic[p]) sig_ok = 1'b0;
            if (p < 16 || p < cap[1])
                crc = crc_step(crc, (p >= 16 && p < 20) ? 8'd0 : b);
            shreg = {b, shreg[63:8]};
            case (p)
                7: if (!sig_ok) begin
                    close_table(STAT_BAD_SIG, 1'b0, v); got = 1'b1; return;
                end
                11: cap[0] = shreg >> 32;
                15: begin
                    cap[1] = shreg >> 32;
                    if (cap[1] < 92 || cap[1] > ss) begin
                        close_table(STAT_HDR_SIZE, 1'b0, v); got = 1'b1; return;
                    end
                end
                19: st_hcrc = shreg[63:32];
                31: cap[2] = shreg;
                39: cap[3] = shreg;
                47: cap[4] = shreg;
                55: cap[5] = shreg;
                79: cap[6] = shreg;
                83: cap[7] = shreg >> 32;
                87: cap[7] = cap[7] | {shreg[63:32], 32'd0};
                91: st_acrc = shreg[63:32];
                default: ;
            endcase
            if (p == ss - 1) begin
                cnt = {32'd0, cap[7][31:0]};
                esz = {32'd0, cap[7][63:32]};
                hmatch = (~crc == st_hcrc);
                got = 1'b1;
                if (cap[2] != cf_hdr_lba) begin
                    close_table(STAT_CUR_LBA, 1'b0, v); return;
                end
                if (esz < 128 || esz > 4096 || cnt == 0 || cnt > 16384) begin
                    close_table(STAT_GEOMETRY, 1'b0, v); return;
                end
                nbytes = cnt * esz;
                if (nbytes > 64'd67108864) begin
                    close_table(STAT_TOO_LARGE, 1'b0, v); return;
                end
                sects = (nbytes + ss - 1) / ss;
                if (cap[6] >= cf_total || sects > cf_total - cap[6]) begin
                    close_table(STAT_ARR_OUT, 1'b0, v); return;
                end
                got = 1'b0;
                ph = PH_ARR; pos = '0; crc = '1;
            end else begin
                pos = pos + 1'b1;
            end
        end else if (ph == PH_ARR) begin
            crc = crc_step(crc, b);
            pos = pos + 1'b1;
            nbytes = cnt * esz;
            if ({37'd0, pos} != nbytes) return;
            eok = (~crc == st_acrc);
            got = 1'b1;
            if (cap[3] >= cf_total || cap[3] == cap[2]) begin
                close_table(STAT_ALT_LBA, eok, v); return;
            end
            if (cap[4] > cap[5] || cap[5] >= cf_total) begin
                close_table(STAT_USABLE, eok, v); return;
            end
            sects = (nbytes + ss - 1) / ss;
            afirst = cap[6];
            alast = afirst + sects - 1;
            if (!(alast < cap[4] || afirst > cap[5])) begin
                close_table(STAT_ARR_OVERLAP, eok, v); return;
            end
            if (cap[2] >= cap[4] && cap[2] <= cap[5]) begin
                close_table(STAT_HDR_OVERLAP, eok, v); return;
            end
            close_table(STAT_OK, eok, v);
        end
    endtask

    task automatic push_item(input logic [7:0] b, input logic first);
        logic got;
        verdict_t v;
        pending_bytes.push_back({first, b});
        n_items++;
        predict_byte(b, first, got, v);
        if (got) begin
            expected_verdicts.push_back(v);
            n_results++;
        end
    endtask

    task automatic put_le(ref logic [7:0] img[], input int off, input logic [63:0] val,
                          input int n);
        for (int k = 0; k < n; k++) img[off + k] = val[8*k +: 8];
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edge_lba(input logic [63:0] cur);
        case ($urandom_range(0, 4))
            0: return 64'd0;
            1: return cf_total;
            2: return cf_total - 1;
            3: return cur;
            default: return rand64();
        endcase
    endfunction

    task automatic run_table(input int kind, input int cut);
        logic [7:0] img[];
        logic [7:0] arr[];
        logic [63:0] ss, hsz, cur, alt, ufirst, ulast, alba, asect;
        logic [31:0] cnt, esz, c;
        int nbytes, total, n;
        ss = eff_ss();
        cnt = $urandom_range(1, 4);
        esz = 128 * $urandom_range(1, 4);
        hsz = $urandom_range(92, ss);
        if (kind == 0) begin
            case ($urandom_range(0, 11))
                0: cnt = 0;
                1: begin cnt = 16384; esz = 127; end
                2: cnt = 16385;
                3: cnt = $urandom;
                default: ;
            endcase
            case ($urandom_range(0, 11))
                0: esz = 0;
                1: esz = 4097;
                2: begin esz = 4096; cnt = 1; end
                3: esz = $urandom;
                default: ;
            endcase
            if (cnt > 4 && esz >= 128 && esz <= 4096) esz = 127;
            case ($urandom_range(0, 5))
                0: hsz = 91;
                1: hsz = ss + 1;
                2: hsz = $urandom_range(0, 1) ? 64'd0 : 64'hFFFF_FFFF;
                default: ;
            endcase
        end
        if (kind == 3) hsz = 91;
        if (kind == 4) hsz = ss + 1;
        if (kind == 6) cnt = 0;
        if (kind == 7) esz = 4097;
        nbytes = (cnt >= 1 && cnt <= 16384 && esz >= 128 && esz <= 4096) ? cnt * esz : 0;
        asect = (nbytes + ss - 1) / ss;
        cur = cf_hdr_lba;
        alba = cur + 1;
        ufirst = alba + asect;
        ulast = cf_total - 3;
        alt = cf_total - 1;
        case (kind)
            0: begin
                if ($urandom_range(0, 15) == 0) cur = edge_lba(cur);
                if ($urandom_range(0, 15) == 0) alt = edge_lba(cur);
                if ($urandom_range(0, 15) == 0) ufirst = edge_lba(cur);
                if ($urandom_range(0, 15) == 0) ulast = edge_lba(cur);
                if ($urandom_range(0, 15) == 0) alba = edge_lba(cur);
            end
            5: cur = cur + 5;
            8: alba = cf_total;
            9: alt = cur;
            10: ufirst = ulast + 1;
            11: ufirst = alba;
            12: begin ufirst = cur; ulast = cur; end
            default: ;
        endcase
        img = new[ss];
        foreach (img[i]) img[i] = $urandom;
        for (int i = 0; i < 8; i++) img[i] = gpt_magic[i];
        if (kind == 2 || (kind == 0 && $urandom_range(0, 4) == 0))
            img[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
        put_le(img, 12, hsz, 4);
        put_le(img, 24, cur, 8);
        put_le(img, 32, alt, 8);
        put_le(img, 40, ufirst, 8);
        put_le(img, 48, ulast, 8);
        put_le(img, 72, alba, 8);
        put_le(img, 80, {32'd0, cnt}, 4);
        put_le(img, 84, {32'd0, esz}, 4);
        arr = new[nbytes];
        c = '1;
        foreach (arr[i]) begin
            arr[i] = $urandom;
            c = crc_step(c, arr[i]);
        end
        c = ~c;
        if ($urandom_range(0, 9) == 0) c ^= 32'h1 << $urandom_range(0, 31);
        put_le(img, 88, {32'd0, c}, 4);
        n = (hsz > ss) ? ss : hsz;
        if (n < 16) n = 16;
        c = '1;
        for (int i = 0; i < n; i++) c = crc_step(c, (i >= 16 && i < 20) ? 8'd0 : img[i]);
        c = ~c;
        if ($urandom_range(0, 9) == 0) c ^= 32'h1 << $urandom_range(0, 31);
        put_le(img, 16, {32'd0, c}, 4);
        total = ss + nbytes;
        if (cut > 0 && cut < total) total = cut;
        n_tables++;
        for (int i = 0; i < total; i++) begin
            push_item((i < ss) ? img[i] : arr[i - ss], i == 0);
            if (ph == PH_IDLE) break;
        end
        if (ph == PH_IDLE && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 5)) push_item($urandom, 1'b0);
    endtask

    task automatic write_cfg(input logic [63:0] lba, input logic [63:0] tot,
                             input logic [12:0] sec);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HEADER_LBA;
        cfg_wdata <= lba;
        @(posedge aclk);
        cfg_index <= CFG_TOTAL_SECTORS;
        cfg_wdata <= tot;
        @(posedge aclk);
        cfg_index <= CFG_SECTOR_BYTES;
        cfg_wdata <= {51'd0, sec};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cf_hdr_lba = lba;
        cf_total = tot;
        cf_sec = sec;
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_bytes.size() != 0) begin
                {s_tuser, s_tdata} <= pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 24) == 0) send_gap <= $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap <= 0;
            hold_cnt <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 15);
        end
    end

    function automatic void cmp_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin : result_check
        verdict_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                $error("result with no expectation pending, status %0d", m_tdata[3:0]);
                errors++;
            end else begin
                e = expected_verdicts.pop_front();
                stat_seen[e.status]++;
                n_checked++;
                cmp_field("status", e.status, m_tdata[3:0]);
                cmp_field("header_crc_good", e.hcrc_ok, m_tdata[4]);
                cmp_field("entries_crc_good", e.ecrc_ok, m_tdata[5]);
                cmp_field("revision_word", e.rev, m_tdata[37:6]);
                cmp_field("header_length", e.hlen, m_tdata[50:38]);
                cmp_field("alternate_lba", e.alt, m_tdata[114:51]);
                cmp_field("usable_first", e.ufirst, m_tdata[178:115]);
                cmp_field("usable_last", e.ulast, m_tdata[242:179]);
                cmp_field("array_lba", e.alba, m_tdata[306:243]);
                cmp_field("number_of_entries", e.nent, m_tdata[321:307]);
                cmp_field("bytes_per_entry", e.esz, m_tdata[334:322]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    initial begin : stimulus
        int target, res_floor, seg, ntab, kinds_seen;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // device too small after reset: every table is rejected on its first item
        hold_req <= 1'b1;
        repeat (10) run_table(0, 3);
        drain();

        write_cfg(64'd1, 64'd4000, 13'd512);
        for (int k = 1; k <= 12; k++) run_table(k, 0);
        drain();

        target = n_items + 1850;
        res_floor = n_results + 40;
        seg = 0;
        while (n_items < target || n_results < res_floor) begin
            quiet = (n_items > target - 300);
            case (seg % 5)
                0: write_cfg(64'd1, 64'd4000, 13'd512);
                1: write_cfg(64'd7, 64'hFFFF_FFFF_FFFF_FFFF, 13'd1024);
                2: write_cfg(64'd33, 64'd100000, 13'd0);
                3: write_cfg(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 13'd512);
                default: write_cfg(64'd0, 64'd50, 13'd8191);
            endcase
            ntab = (eff_ss() > 1024) ? 2 : 6;
            for (int t = 0; t < ntab; t++)
                run_table(0, (t < ntab - 1 && $urandom_range(0, 9) == 0) ?
                          $urandom_range(1, 120) : 0);
            drain();
            seg++;
        end

        if (expected_verdicts.size() != 0) begin
            $error("%0d expected results never arrived", expected_verdicts.size());
            errors++;
        end
        kinds_seen = 0;
        foreach (stat_seen[i]) if (stat_seen[i] > 0) kinds_seen++;
        $display("Sent %0d items in %0d tables over %0d setting phases; checked %0d results",
                 n_items, n_tables, seg + 2, n_checked);
        $display("Distinct status codes observed: %0d", kinds_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
